@@ rtl/bdcd_pkg.sv @@
`default_nettype none

package bdcd_pkg;

  // Event codes reported on the result channel
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_CLICK  = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_LONG   = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_DOUBLE   = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;
  localparam logic [1:0] REG_LEVEL    = 2'd3;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] DOUBLE_RST   = 16'd250;
  localparam logic [15:0] LONG_RST     = 16'd1000;
  localparam logic        LEVEL_RST    = 1'b0;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Configuration as seen by the classifier
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] double_click_ms;
    logic [15:0] long_press_ms;
    logic        pressed_level;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/bdcd_engine.sv @@
`default_nettype none

// Debounce and click classification state, updated once per processed poll.
module bdcd_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bdcd_pkg::cfg_t cfg_i,
  input  wire logic           adv_i,
  input  wire logic           pin_level_i,
  input  wire logic [31:0]    now_ms_i,
  output logic [1:0]          event_code_o
);

  logic        stable_q, stable_d;
  logic        active_q, active_d;
  logic [31:0] dbend_q, dbend_d;
  logic [31:0] ptime_q, ptime_d;
  logic        pseen_q, pseen_d;
  logic        rseen_q, rseen_d;
  logic [7:0]  count_q, count_d;
  logic [1:0]  ev;

  logic [31:0] db_diff;
  logic [31:0] elapsed;
  logic        win_old;
  logic        long_over;

  assign db_diff   = now_ms_i - dbend_q;
  assign elapsed   = now_ms_i - ptime_q;
  assign win_old   = pseen_q && (elapsed[31:16] == 16'd0) &&
                     (elapsed[15:0] <= cfg_i.double_click_ms);
  assign long_over = (elapsed[31:16] != 16'd0) || (elapsed[15:0] > cfg_i.long_press_ms);

  // Next state and event for the poll in the input register
  always_comb begin
    logic win_new;
    logic hold;
    stable_d = stable_q;
    active_d = active_q;
    dbend_d  = dbend_q;
    ptime_d  = ptime_q;
    pseen_d  = pseen_q;
    rseen_d  = rseen_q;
    count_d  = count_q;
    win_new  = win_old;
    hold     = active_q && db_diff[31];
    ev       = bdcd_pkg::EV_NONE;

    if (!hold) begin
      if (pin_level_i != stable_q) begin
        if (active_q) begin
          // change survived the window: accept it
          active_d = 1'b0;
          stable_d = pin_level_i;
          if (pin_level_i == cfg_i.pressed_level) begin
            rseen_d = 1'b0;
            if (win_old) begin
              if (count_q != bdcd_pkg::COUNT_MAX) begin
                count_d = count_q + 8'd1;
              end
            end else begin
              ptime_d = now_ms_i;
              pseen_d = 1'b1;
              count_d = 8'd1;
              win_new = 1'b1;
            end
          end else if (pseen_q) begin
            rseen_d = 1'b1;
          end
        end else begin
          active_d = 1'b1;
          dbend_d  = now_ms_i + {16'd0, cfg_i.debounce_ms};
        end
      end else begin
        active_d = 1'b0;
      end
    end

    // Classify once settled and outside the double-click window
    if (!active_d && !win_new && pseen_d) begin
      if (rseen_d) begin
        ev = (count_d > 8'd1) ? bdcd_pkg::EV_DOUBLE : bdcd_pkg::EV_CLICK;
      end else if (long_over) begin
        ev = bdcd_pkg::EV_LONG;
      end
    end

    // Reported: drop the record and resync to the pin
    if (ev != bdcd_pkg::EV_NONE) begin
      stable_d = pin_level_i;
      active_d = 1'b0;
      pseen_d  = 1'b0;
      rseen_d  = 1'b0;
      count_d  = 8'd0;
    end
  end

  assign event_code_o = ev;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= ~bdcd_pkg::LEVEL_RST;
      active_q <= 1'b0;
      pseen_q  <= 1'b0;
      rseen_q  <= 1'b0;
      count_q  <= 8'd0;
    end else if (adv_i) begin
      stable_q <= stable_d;
      active_q <= active_d;
      pseen_q  <= pseen_d;
      rseen_q  <= rseen_d;
      count_q  <= count_d;
    end
  end

  // Time stamps, only read while their flags are set
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dbend_q <= dbend_d;
      ptime_q <= ptime_d;
    end
  end

  a_count_tracks_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pseen_q == (count_q != 8'd0))
    else $error("press count out of step with press record");

  a_release_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rseen_q |-> pseen_q)
    else $error("release recorded without a press");

  a_event_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && ev != bdcd_pkg::EV_NONE) |=> (!pseen_q && !active_q))
    else $error("press record not cleared after an event");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> ($stable(stable_q) && $stable(count_q) && $stable(active_q)))
    else $error("state changed without a poll");

endmodule

`default_nettype wire

@@ rtl/button_debounce_click_detector.sv @@
`default_nettype none

// Button debounce and click detector.
// Input stream: one poll per transaction, carrying the raw pin level and the
// current millisecond time. Output stream: one event code per poll
// (none, click, double click, long press), in poll order.
// Registers on the APB port: 0x0 debounce_ms, 0x4 double_click_ms,
// 0x8 long_press_ms, 0xC pressed_level. Write them only while idle.
// Path: an accepted poll waits in the input register, is classified as it
// moves on, and its event is held in the result register and valid on the
// output from then on.
// Throughput: one poll per cycle while the receiver keeps m_axis_tready high;
// the classifier is a single pass of compares and 32-bit time subtractions
// between the input and result registers.
// Stall: when the receiver holds m_axis_tready low, the result register
// keeps its event, the input register keeps one further poll, and only then
// does s_axis_tready drop.
// Reset: registers return to 50 / 250 / 1000 ms with pull-up wiring
// (pressed level low), the button is taken as released, no press recorded,
// and both register stages are emptied.
module button_debounce_click_detector (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Poll stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // [0] pin_level, [32:1] now_ms, rest zero
  // Event stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // [1:0] event_code, rest zero
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  bdcd_pkg::cfg_t cfg_q;

  logic        in_valid_q;
  logic        in_level_q;
  logic [31:0] in_now_q;
  logic        out_valid_q;
  logic [1:0]  out_code_q;
  logic [1:0]  ev_code;
  logic        adv;
  logic        s_acc;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= bdcd_pkg::DEBOUNCE_RST;
      cfg_q.double_click_ms <= bdcd_pkg::DOUBLE_RST;
      cfg_q.long_press_ms   <= bdcd_pkg::LONG_RST;
      cfg_q.pressed_level   <= bdcd_pkg::LEVEL_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        bdcd_pkg::REG_DEBOUNCE: cfg_q.debounce_ms     <= pwdata[15:0];
        bdcd_pkg::REG_DOUBLE:   cfg_q.double_click_ms <= pwdata[15:0];
        bdcd_pkg::REG_LONG:     cfg_q.long_press_ms   <= pwdata[15:0];
        bdcd_pkg::REG_LEVEL:    cfg_q.pressed_level   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      bdcd_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
      bdcd_pkg::REG_DOUBLE:   prdata = {16'd0, cfg_q.double_click_ms};
      bdcd_pkg::REG_LONG:     prdata = {16'd0, cfg_q.long_press_ms};
      bdcd_pkg::REG_LEVEL:    prdata = {31'd0, cfg_q.pressed_level};
      default:                prdata = 32'd0;
    endcase
  end

  // Handshakes: the held poll moves on when the result register is free
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_level_q <= s_axis_tdata_i[0];
      in_now_q   <= s_axis_tdata_i[32:1];
    end
    if (adv) begin
      out_code_q <= ev_code;
    end
  end

  bdcd_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .adv_i        (adv),
    .pin_level_i  (in_level_q),
    .now_ms_i     (in_now_q),
    .event_code_o (ev_code)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_code_q};

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i && in_valid_q) |-> !s_axis_tready_o)
    else $error("poll accepted with both stages full");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("processed poll left no result");

  a_stall_holds_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !adv) |=> (in_valid_q && $stable(in_now_q) && $stable(in_level_q)))
    else $error("held poll changed while stalled");

endmodule

`default_nettype wire

@@ tb/button_debounce_click_detector_tb.sv @@
`timescale 1ns / 100ps

module button_debounce_click_detector_tb;

  localparam int QUIET_LIMIT = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;  // [0] pin_level, [32:1] now_ms, rest zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;  // [1:0] event_code, rest zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  button_debounce_click_detector dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Shadow configuration
  logic [15:0] cfg_debounce;
  logic [15:0] cfg_double;
  logic [15:0] cfg_long;
  logic        cfg_level;

  // Shadow button state
  logic        btn_stable;
  logic        btn_deb_active;
  logic [31:0] btn_deb_end;
  logic [31:0] btn_press_time;
  logic        btn_press_seen;
  logic [31:0] btn_release_time;
  logic        btn_release_seen;
  logic [7:0]  btn_count;

  logic [1:0]  pending_events[$];
  logic [1:0]  want_event;
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  logic        steady_flow = 1'b0;
  logic [31:0] wall_ms = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Button model
  // ---------------------------------------------------------------------------

  function automatic void clear_press_record(input logic level);
    btn_stable       = level;
    btn_deb_active   = 1'b0;
    btn_deb_end      = '0;
    btn_press_time   = '0;
    btn_press_seen   = 1'b0;
    btn_release_time = '0;
    btn_release_seen = 1'b0;
    btn_count        = '0;
  endfunction

  function automatic void reset_button_model();
    cfg_debounce = bdcd_pkg::DEBOUNCE_RST;
    cfg_double   = bdcd_pkg::DOUBLE_RST;
    cfg_long     = bdcd_pkg::LONG_RST;
    cfg_level    = bdcd_pkg::LEVEL_RST;
    clear_press_record(~bdcd_pkg::LEVEL_RST);
  endfunction

  function automatic logic in_click_window(input logic [31:0] now);
    logic [31:0] since;
    since = now - btn_press_time;
    return btn_press_seen && (since <= {16'd0, cfg_double});
  endfunction

  // Debounced edge: a press opens or extends a sequence, a release is noted
  function automatic void take_level(input logic level, input logic [31:0] now);
    if (level == cfg_level) begin
      if (in_click_window(now)) begin
        if (btn_count != bdcd_pkg::COUNT_MAX) btn_count++;
        btn_release_seen = 1'b0;
      end else begin
        btn_press_time   = now;
        btn_press_seen   = 1'b1;
        btn_release_seen = 1'b0;
        btn_count        = 8'd1;
      end
    end else if (btn_press_seen) begin
      btn_release_time = now;
      btn_release_seen = 1'b1;
    end
  endfunction

  function automatic logic [1:0] classify_poll(input logic level, input logic [31:0] now);
    logic [31:0] past_end;
    logic [31:0] held;
    logic [1:0]  ev;
    past_end = now - btn_deb_end;
    ev       = bdcd_pkg::EV_NONE;
    // an open window that has not yet run out blocks the sample
    if (!(btn_deb_active && past_end[31])) begin
      if (level != btn_stable) begin
        if (btn_deb_active) begin
          btn_deb_active = 1'b0;
          btn_stable     = level;
          take_level(level, now);
        end else begin
          btn_deb_active = 1'b1;
          btn_deb_end    = now + {16'd0, cfg_debounce};
        end
      end else begin
        btn_deb_active = 1'b0;
      end
    end
    if (!btn_deb_active && !in_click_window(now)) begin
      if (btn_press_seen && btn_release_seen) begin
        ev = (btn_count > 8'd1) ? bdcd_pkg::EV_DOUBLE : bdcd_pkg::EV_CLICK;
      end else if (btn_press_seen) begin
        held = now - btn_press_time;
        if (held > {16'd0, cfg_long}) ev = bdcd_pkg::EV_LONG;
      end
    end
    if (ev != bdcd_pkg::EV_NONE) clear_press_record(level);
    return ev;
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      bdcd_pkg::REG_DEBOUNCE: cfg_debounce = val[15:0];
      bdcd_pkg::REG_DOUBLE:   cfg_double   = val[15:0];
      bdcd_pkg::REG_LONG:     cfg_long     = val[15:0];
      bdcd_pkg::REG_LEVEL:    cfg_level    = val[0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] register_value(input logic [1:0] idx);
    case (idx)
      bdcd_pkg::REG_DEBOUNCE: return {16'd0, cfg_debounce};
      bdcd_pkg::REG_DOUBLE:   return {16'd0, cfg_double};
      bdcd_pkg::REG_LONG:     return {16'd0, cfg_long};
      default:                return {31'd0, cfg_level};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Transaction monitors and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: event 0x%02h with no poll outstanding", $realtime, m_axis_tdata_o);
      end else begin
        want_event = pending_events.pop_front();
        if (m_axis_tdata_o !== {6'd0, want_event}) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: event_code expected %0d, got 0x%02h", $realtime, want_event,
                     m_axis_tdata_o);
        end
      end
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      pending_events.push_back(classify_poll(s_axis_tdata_i[0], s_axis_tdata_i[32:1]));
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Event receiver: random stalls, or a counted hold-off when requested
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i = steady_flow || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  task automatic send_poll(input logic level, input logic [31:0] now);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {7'd0, now, level};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    if (!steady_flow && $urandom_range(0, 99) < 25)
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
  endtask

  task automatic poll_after(input logic level, input logic [31:0] dt);
    wall_ms = wall_ms + dt;
    send_poll(level, wall_ms);
  endtask

  task automatic apb_access(input logic write, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    = 1'b1;
    pwrite  = write;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (write) apply_register(idx, wdata);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [31:0] readback;
    apb_access(1'b0, idx, '0, readback);
    if (readback !== register_value(idx)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: register %0d expected 0x%08h, read 0x%08h", $realtime, idx,
                 register_value(idx), readback);
    end
  endtask

  // Write with random junk above the register width, then read it back
  task automatic program_register(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] junk;
    logic [31:0] unused;
    junk = $urandom;
    junk = (idx == bdcd_pkg::REG_LEVEL) ? {junk[31:1], value[0]} : {junk[31:16], value};
    apb_access(1'b1, idx, junk, unused);
    check_register(idx);
  endtask

  task automatic program_all(input logic [15:0] deb, input logic [15:0] dbl,
                             input logic [15:0] lng, input logic lvl);
    program_register(bdcd_pkg::REG_DEBOUNCE, deb);
    program_register(bdcd_pkg::REG_DOUBLE, dbl);
    program_register(bdcd_pkg::REG_LONG, lng);
    program_register(bdcd_pkg::REG_LEVEL, {15'd0, lvl});
  endtask

  // Block is idle once every event is back; allow the pipeline to settle
  task automatic wait_drained();
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, then click, double click, long press, reverted level,
  // release with nothing pressed and the millisecond counter wrapping
  task automatic test_directed_cases();
    check_register(bdcd_pkg::REG_DEBOUNCE);
    check_register(bdcd_pkg::REG_DOUBLE);
    check_register(bdcd_pkg::REG_LONG);
    check_register(bdcd_pkg::REG_LEVEL);
    wall_ms = '0;
    poll_after(1'b1, 0);
    // bounce that has gone back by the first poll after the window runs out
    poll_after(1'b0, 10);
    poll_after(1'b1, 60);
    // single click
    poll_after(1'b0, 10);
    poll_after(1'b0, 60);
    poll_after(1'b1, 40);
    poll_after(1'b1, 60);
    poll_after(1'b1, 300);
    // double click
    poll_after(1'b0, 10);
    poll_after(1'b0, 55);
    poll_after(1'b1, 10);
    poll_after(1'b1, 55);
    poll_after(1'b0, 10);
    poll_after(1'b0, 55);
    poll_after(1'b1, 10);
    poll_after(1'b1, 55);
    poll_after(1'b1, 300);
    // long press, then its release lands with no press on record
    poll_after(1'b0, 10);
    poll_after(1'b0, 60);
    poll_after(1'b0, 1100);
    poll_after(1'b1, 10);
    poll_after(1'b1, 60);
    // click straddling the counter wrap
    wall_ms = 32'hFFFF_FFFF;
    poll_after(1'b0, 0);
    poll_after(1'b0, 60);
    poll_after(1'b1, 20);
    poll_after(1'b1, 60);
    poll_after(1'b1, 400);
  endtask

  task automatic test_register_extremes();
    wait_drained();
    program_all(16'd0, 16'd0, 16'd0, 1'b1);
    repeat (8) poll_after(1'($urandom_range(0, 1)), $urandom_range(0, 1));
    wait_drained();
    program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    repeat (6) poll_after(1'($urandom_range(0, 1)), $urandom_range(0, 70000));
    // settle released, then hold just past the longest long-press time
    poll_after(1'b1, 70000);
    poll_after(1'b1, 70000);
    poll_after(1'b0, 0);
    poll_after(1'b0, 65535);
    poll_after(1'b0, 65536);
    poll_after(1'b1, 70000);
    poll_after(1'b1, 70000);
  endtask

  // Receiver holds off while polls keep coming, so the input side stalls
  task automatic test_backpressure();
    wait_drained();
    program_all(16'd4, 16'd30, 16'd60, 1'b0);
    @(posedge clk_i);
    hold_left = 80;
    @(negedge clk_i);
    steady_flow = 1'b1;
    repeat (40) poll_after(1'($urandom_range(0, 1)), $urandom_range(0, 20));
    steady_flow = 1'b0;
  endtask

  // Held levels with bounce, sized around the current timing settings
  task automatic button_activity(input int count);
    int   sent;
    int   hold_ms;
    int   elapsed;
    int   step;
    logic intended;
    sent     = 0;
    intended = 1'($urandom_range(0, 1));
    while (sent < count) begin
      case ($urandom_range(0, 2))
        0:       hold_ms = $urandom_range(0, int'(cfg_debounce) + int'(cfg_double));
        1:       hold_ms = $urandom_range(int'(cfg_debounce), 2 * int'(cfg_double) + 10);
        default: hold_ms = $urandom_range(int'(cfg_long), 2 * int'(cfg_long) + 20);
      endcase
      elapsed = 0;
      while (elapsed <= hold_ms && sent < count) begin
        step = $urandom_range(0, int'(cfg_debounce) / 2 + 2);
        if ($urandom_range(0, 99) == 0) begin
          // wild jump of the clock, may look like time running backwards
          poll_after(intended, $urandom);
          elapsed = hold_ms + 1;
        end else begin
          poll_after(($urandom_range(0, 99) < 12) ? ~intended : intended, step);
          elapsed += step;
        end
        sent++;
      end
      intended = ~intended;
    end
  endtask

  task automatic test_random_sessions();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      program_all(16'($urandom_range(0, 8)), 16'($urandom_range(0, 80)),
                  16'($urandom_range(0, 150)), 1'($urandom_range(0, 1)));
      steady_flow = (phase == 3);
      button_activity(85);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    reset_button_model();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_register_extremes();
    test_backpressure();
    test_random_sessions();

    wait_drained();
    if (fail_count == 0 && pending_events.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
